/* design/dfap_pkg.sv */
// Shared types and constants for the dropped-frame angle predictor.
// No dependencies.
`timescale 1ns / 1ps

package dfap_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN = 1'b1;

  localparam logic [15:0] LOST_LIMIT_RST = 16'd10;
  localparam logic [15:0] ALPHA_GAIN_RST = 16'd256;
  localparam logic [15:0] LOSS_MAX       = 16'hFFFF;
  localparam int          RATE_CAP       = 32768;

  typedef struct packed {
    logic               target_found;
    logic signed [31:0] pitch_in;
    logic signed [31:0] yaw_in;
    logic        [31:0] distance_in;
  } in_req_t;

  typedef struct packed {
    logic               frame_dropped;
    logic        [15:0] lost_frames;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] pred_yaw;
    logic signed [31:0] pred_pitch;
    logic        [31:0] pred_distance;
  } out_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_TRIM, S_SUMRD, S_SUMACC, S_DIVA, S_DIVAW, S_DIVB,
    S_DIVBW, S_SAT, S_NEXT, S_PMUL1, S_PMUL2, S_PADD, S_DONE
  } dfap_state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic trim;
    logic rd;
    logic acc;
    logic div_a;
    logic div_b;
    logic speed_zero;
    logic speed_wr;
    logic mul1;
    logic mul2;
    logic pred_wr;
    logic out_load;
    logic sel;       // 0: yaw window, 1: pitch window
  } dfap_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_one;
    logic sum_last;
    logic div_done;
  } dfap_status_t;

endpackage

/* design/dfap_div.sv */
// Iterative restoring divider, one quotient bit per cycle, truncating.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module dfap_div #(
  parameter int unsigned AW = 37,
  parameter int unsigned HW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] dividend_i,
  input  logic        [HW-1:0] divisor_i,
  output logic signed [AW-1:0] quotient_o,
  output logic                 done_o
);

  localparam int unsigned CW = $clog2(AW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [HW-1:0] rem_q, rem_d;
  logic [AW-1:0] quo_q, quo_d;
  logic [HW-1:0] dvs_q, dvs_d;
  logic [HW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[AW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[AW-1];
      quo_d  = dividend_i[AW-1] ? -dividend_i : dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(AW);
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = HW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[AW-2:0], 1'b1};
      end else begin
        rem_d = trial[HW-1:0];
        quo_d = {quo_q[AW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign done_o     = done_q;

endmodule

/* design/dfap_dp.sv */
// Datapath: window memories, fill/head pointers, sum, divide, prediction.
// Depends on dfap_pkg and dfap_div.
`timescale 1ns / 1ps

module dfap_dp import dfap_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_req_t               in_req_i,
  input  dfap_cmd_t             cmd_i,
  output dfap_status_t          status_o,
  output out_req_t              out_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned AW = 32 + IW + 1;
  localparam logic signed [AW-1:0] SPD_CAP = AW'(RATE_CAP);
  localparam logic signed [AW-1:0] SPD_MIN = {{(AW-32){1'b1}}, 32'h8000_0000};

  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IW+1)'(DEPTH)) s = s - (IW+1)'(DEPTH);
    return s[IW-1:0];
  endfunction

  function automatic logic opp(logic signed [31:0] a, logic signed [31:0] b);
    return (a > 0 && b < 0) || (a < 0 && b > 0);
  endfunction

  function automatic logic signed [31:0] extrap(logic signed [31:0] last,
                                                logic signed [64:0] p);
    logic signed [65:0] t;
    t = 66'(p);
    if (p < 0) t = t + 66'sd255;
    t = t >>> 8;
    t = t + 66'(last);
    if (t > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (t < -66'sd2147483648) return 32'sh8000_0000;
    return t[31:0];
  endfunction

  logic signed [31:0] y_mem [DEPTH];
  logic signed [31:0] p_mem [DEPTH];

  in_req_t            in_q;
  logic [15:0]        lost_limit_q, alpha_q, loss_q;
  logic [31:0]        held_dist_q, pred_d_q;
  logic [IW-1:0]      y_head_q, p_head_q, idx_q;
  logic [FW-1:0]      y_fill_q, p_fill_q;
  logic signed [31:0] y_last_q, p_last_q, y_spd_q, p_spd_q, pred_y_q, pred_p_q;
  logic signed [31:0] y_rd_q, p_rd_q;
  logic signed [AW-1:0] acc_q;
  logic [31:0]        al_q;
  logic signed [64:0] py_q, pp_q;
  out_req_t           out_q;

  logic               found, clr_all, y_clr, p_clr, y_full, p_full, dropped;
  logic [FW-1:0]      y_feff, p_feff, sel_fill, half;
  logic [IW-1:0]      y_waddr, p_waddr, y_raddr, p_raddr;
  logic               y_we, p_we;
  logic signed [31:0] rd_sel;
  logic signed [AW-1:0] div_q, spd_sat;
  logic               div_done;

  assign found   = in_q.target_found;
  assign clr_all = loss_q != 16'd0;
  assign y_clr   = clr_all || (y_fill_q != '0 && opp(y_last_q, in_q.yaw_in));
  assign p_clr   = clr_all || (p_fill_q != '0 && opp(p_last_q, in_q.yaw_in));
  assign y_feff  = y_clr ? '0 : y_fill_q;
  assign p_feff  = p_clr ? '0 : p_fill_q;
  assign y_full  = y_feff == FW'(DEPTH);
  assign p_full  = p_feff == FW'(DEPTH);
  assign y_waddr = y_full ? y_head_q : wrap_add(y_head_q, y_feff[IW-1:0]);
  assign p_waddr = p_full ? p_head_q : wrap_add(p_head_q, p_feff[IW-1:0]);
  assign y_we    = cmd_i.update && found;
  assign p_we    = cmd_i.update && found;
  assign y_raddr = wrap_add(y_head_q, idx_q);
  assign p_raddr = wrap_add(p_head_q, idx_q);

  assign sel_fill = cmd_i.sel ? p_fill_q : y_fill_q;
  assign half     = sel_fill >> 1;
  assign rd_sel   = cmd_i.sel ? p_rd_q : y_rd_q;
  assign dropped  = (loss_q != 16'd0) && (loss_q < lost_limit_q);

  always_comb begin
    spd_sat = div_q;
    if (div_q > SPD_CAP) spd_sat = SPD_CAP;
    else if (div_q < SPD_MIN) spd_sat = SPD_MIN;
  end

  dfap_div #(.AW(AW), .HW(IW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_a || cmd_i.div_b),
    .dividend_i (cmd_i.div_b ? div_q : acc_q),
    .divisor_i  (half[IW-1:0]),
    .quotient_o (div_q),
    .done_o     (div_done)
  );

  // window storage, no reset
  always_ff @(posedge clk_i) begin
    if (y_we) y_mem[y_waddr] <= in_q.yaw_in;
    if (p_we) p_mem[p_waddr] <= in_q.pitch_in;
    if (cmd_i.rd) begin
      y_rd_q <= y_mem[y_raddr];
      p_rd_q <= p_mem[p_raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_req_i;
    if (y_we) y_last_q <= in_q.yaw_in;
    if (p_we) p_last_q <= in_q.pitch_in;
    if (cmd_i.trim) begin
      idx_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      idx_q <= idx_q + IW'(1);
      if (FW'(idx_q) >= half) acc_q <= acc_q + AW'(rd_sel);
      else                    acc_q <= acc_q - AW'(rd_sel);
    end
    if (cmd_i.mul1) al_q <= alpha_q * loss_q;
    if (cmd_i.mul2) begin
      py_q <= $signed({1'b0, al_q}) * y_spd_q;
      pp_q <= $signed({1'b0, al_q}) * p_spd_q;
    end
    if (cmd_i.out_load) begin
      out_q.frame_dropped <= dropped;
      out_q.lost_frames   <= loss_q;
      out_q.yaw_rate      <= y_spd_q;
      out_q.pitch_rate    <= p_spd_q;
      out_q.pred_yaw      <= pred_y_q;
      out_q.pred_pitch    <= pred_p_q;
      out_q.pred_distance <= pred_d_q;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_limit_q <= LOST_LIMIT_RST;
      alpha_q      <= ALPHA_GAIN_RST;
      loss_q       <= '0;
      held_dist_q  <= '0;
      y_head_q     <= '0;
      p_head_q     <= '0;
      y_fill_q     <= '0;
      p_fill_q     <= '0;
      y_spd_q      <= '0;
      p_spd_q      <= '0;
      pred_y_q     <= '0;
      pred_p_q     <= '0;
      pred_d_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOST_LIMIT: lost_limit_q <= cfg_data_i;
          CFG_ALPHA_GAIN: alpha_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        if (found) begin
          loss_q      <= '0;
          held_dist_q <= in_q.distance_in;
          if (y_full) y_head_q <= wrap_add(y_head_q, IW'(1));
          else        y_fill_q <= y_feff + FW'(1);
          if (p_full) p_head_q <= wrap_add(p_head_q, IW'(1));
          else        p_fill_q <= p_feff + FW'(1);
        end else if (loss_q != LOSS_MAX) begin
          loss_q <= loss_q + 16'd1;
        end
      end
      // odd count above one: drop the oldest entry
      if (cmd_i.trim && sel_fill[0] && sel_fill != FW'(1)) begin
        if (cmd_i.sel) begin
          p_head_q <= wrap_add(p_head_q, IW'(1));
          p_fill_q <= p_fill_q - FW'(1);
        end else begin
          y_head_q <= wrap_add(y_head_q, IW'(1));
          y_fill_q <= y_fill_q - FW'(1);
        end
      end
      if (cmd_i.speed_zero) begin
        if (cmd_i.sel) p_spd_q <= '0;
        else           y_spd_q <= '0;
      end else if (cmd_i.speed_wr) begin
        if (cmd_i.sel) p_spd_q <= spd_sat[31:0];
        else           y_spd_q <= spd_sat[31:0];
      end
      if (cmd_i.pred_wr && dropped && y_fill_q != '0 && p_fill_q != '0) begin
        pred_y_q <= extrap(y_last_q, py_q);
        pred_p_q <= extrap(p_last_q, pp_q);
        pred_d_q <= held_dist_q;
      end
    end
  end

  assign status_o.fill_zero = sel_fill == '0;
  assign status_o.fill_one  = sel_fill == FW'(1);
  assign status_o.sum_last  = FW'(idx_q) == sel_fill - FW'(1);
  assign status_o.div_done  = div_done;
  assign out_o              = out_q;

  a_yfill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_fill_q <= FW'(DEPTH)) else $error("yaw fill beyond depth");
  a_pfill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_fill_q <= FW'(DEPTH)) else $error("pitch fill beyond depth");
  a_sum_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> !sel_fill[0] && sel_fill != '0)
    else $error("summing a window with odd count");

endmodule

/* design/dfap_ctrl.sv */
// Sequencer for the predictor: handshakes and datapath commands.
// Depends on dfap_pkg.
`timescale 1ns / 1ps

module dfap_ctrl import dfap_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  dfap_status_t status_i,
  output dfap_cmd_t    cmd_o
);

  dfap_state_e state_q, state_d;
  logic        sel_q, sel_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_UPD;
      S_UPD:    state_d = S_TRIM;
      S_TRIM: begin
        if (status_i.fill_zero || status_i.fill_one) state_d = S_NEXT;
        else state_d = S_SUMRD;
      end
      S_SUMRD:  state_d = S_SUMACC;
      S_SUMACC: state_d = status_i.sum_last ? S_DIVA : S_SUMRD;
      S_DIVA:   state_d = S_DIVAW;
      S_DIVAW:  if (status_i.div_done) state_d = sel_q ? S_SAT : S_DIVB;
      S_DIVB:   state_d = S_DIVBW;
      S_DIVBW:  if (status_i.div_done) state_d = S_SAT;
      S_SAT:    state_d = S_NEXT;
      S_NEXT:   state_d = sel_q ? S_PMUL1 : S_TRIM;
      S_PMUL1:  state_d = S_PMUL2;
      S_PMUL2:  state_d = S_PADD;
      S_PADD:   state_d = S_DONE;
      S_DONE:   if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.sel        = sel_q;
    sel_d            = sel_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        sel_d         = 1'b0;
      end
      S_UPD:    cmd_o.update = 1'b1;
      S_TRIM: begin
        cmd_o.trim       = 1'b1;
        cmd_o.speed_zero = status_i.fill_one;
      end
      S_SUMRD:  cmd_o.rd = 1'b1;
      S_SUMACC: cmd_o.acc = 1'b1;
      S_DIVA:   cmd_o.div_a = 1'b1;
      S_DIVB:   cmd_o.div_b = 1'b1;
      S_SAT:    cmd_o.speed_wr = 1'b1;
      S_NEXT:   sel_d = 1'b1;
      S_PMUL1:  cmd_o.mul1 = 1'b1;
      S_PMUL2:  cmd_o.mul2 = 1'b1;
      S_PADD:   cmd_o.pred_wr = 1'b1;
      S_DONE:   cmd_o.out_load = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> slot_free) else $error("result overwritten");
  a_second_div_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVB |-> !sel_q) else $error("second division on pitch");
  a_pred_after_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PMUL1 |-> $past(sel_q)) else $error("prediction before pitch");

endmodule

/* design/dropped_frame_angle_predictor.sv */
// Dropped-frame angle predictor: one request per camera frame, one result each.
// Per window of n >= 2 entries after trimming, the sequencer sums the window,
// runs its divisions (yaw two, pitch one) on the shared bit-serial divider of
// width AW = 33 + log2(WINDOW_DEPTH) and saturates the rate. One request in
// flight, next accepted in the cycle after the result loads. Reset empties both
// windows and restores lost_limit = 10 and alpha_gain = 1.0; window memories
// are not cleared.
`timescale 1ns / 1ps

module dropped_frame_angle_predictor import dfap_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_req_t              out_req_o
);

  dfap_cmd_t    cmd;
  dfap_status_t status;

  // sequencer: frame update, per-window sum/divide, prediction, result load
  dfap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // windows live in circular memories with head pointer and fill count
  dfap_dp #(.DEPTH(WINDOW_DEPTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_o      (out_req_o)
  );

endmodule
